// File: rtl/kps_pkg.sv
// shared constants and controller/datapath command and status types
// for the key run partition block; no dependencies
`default_nettype none

package kps_pkg;

  localparam int KPS_MAX_KEYS  = 1024;
  localparam int KPS_MAX_PARTS = 16;
  localparam int KPS_KEY_BITS  = 32;
  localparam int KPS_CFG_W     = 5;
  localparam int KPS_OUT_W     = 11;

  typedef struct packed {
    logic load_en;
    logic div_step;
    logic rd_pos;
    logic ref_cap;
    logic rd_b;
    logic b_inc;
    logic b_len;
    logic push_mid;
    logic push_last;
  } kps_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_last;
    logic div_last;
    logic pos_ge_len;
    logic b_ge_len;
    logic key_eq;
    logic out_free;
    logic idx_end;
  } kps_status_t;

endpackage

`default_nettype wire

// File: rtl/kps_key_if.sv
// input channel: one key word with its end-of-batch mark
// depends on kps_pkg
`default_nettype none

interface kps_key_if
  import kps_pkg::*;
#(
  parameter int KEY_BITS = KPS_KEY_BITS
);
  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] key;
  logic                last_key;

  modport source (output valid, output key, output last_key, input ready);
  modport sink   (input valid, input key, input last_key, output ready);
endinterface

`default_nettype wire

// File: rtl/kps_part_if.sv
// result channel: one part word with offset, length and final mark
// depends on kps_pkg
`default_nettype none

interface kps_part_if
  import kps_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [KPS_OUT_W-1:0] part_offset;
  logic [KPS_OUT_W-1:0] part_length;
  logic                 last_part;

  modport source (output valid, output part_offset, output part_length,
                  output last_part, input ready);
  modport sink   (input valid, input part_offset, input part_length,
                  input last_part, output ready);
endinterface

`default_nettype wire

// File: rtl/kps_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module kps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/kps_ctrl.sv
// sequencer for load, gap division, boundary walk and part output
// depends on kps_pkg
`default_nettype none

module kps_ctrl
  import kps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire kps_status_t st,
  output kps_cmd_t         cmd
);

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_DIV   = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_REF   = 8'b0000_1000,
    S_SCAN  = 8'b0001_0000,
    S_CMP   = 8'b0010_0000,
    S_PUSH  = 8'b0100_0000,
    S_LAST  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_LOAD: begin
        cmd.load_en = 1'b1;
        if (st.in_fire && st.in_last) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.idx_end) begin
          state_nxt = S_LAST;
        end else if (st.pos_ge_len) begin
          cmd.b_len = 1'b1;
          state_nxt = S_PUSH;
        end else begin
          cmd.rd_pos = 1'b1;
          state_nxt  = S_REF;
        end
      end
      S_REF: begin
        cmd.ref_cap = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        if (st.b_ge_len) begin
          state_nxt = S_PUSH;
        end else begin
          cmd.rd_b  = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (st.key_eq) begin
          cmd.b_inc = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (st.out_free) begin
          cmd.push_mid = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_LAST: begin
        if (st.out_free) begin
          cmd.push_last = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/kps_dp.sv
// datapath: key store, counters, restoring divider, run scan and output register
// depends on kps_pkg, kps_ram, kps_key_if and kps_part_if
`default_nettype none

module kps_dp
  import kps_pkg::*;
#(
  parameter int MAX_KEYS  = KPS_MAX_KEYS,
  parameter int MAX_PARTS = KPS_MAX_PARTS,
  parameter int KEY_BITS  = KPS_KEY_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [KPS_CFG_W-1:0] cfg_wdata,
  kps_key_if.sink                   in,
  kps_part_if.source                out,
  input  wire kps_cmd_t             cmd,
  output kps_status_t               st
);

  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int ADDR_W = $clog2(MAX_KEYS);
  localparam int PART_W = $clog2(MAX_PARTS + 1);
  localparam int DC_W   = $clog2(CNT_W);

  logic [KPS_CFG_W-1:0] pcnt_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     len_r;
  logic [PART_W-1:0]    parts_r;
  logic [CNT_W-1:0]     quo_r, quo_nxt;
  logic [PART_W-1:0]    rem_r, rem_nxt;
  logic [DC_W-1:0]      dcnt_r;
  logic [CNT_W:0]       pos_r;
  logic [CNT_W-1:0]     b_r;
  logic [CNT_W-1:0]     prev_r;
  logic [PART_W-1:0]    idx_r;
  logic [KEY_BITS-1:0]  ref_r;
  logic [KEY_BITS-1:0]  rdata;
  logic                 out_valid_r;
  logic [KPS_OUT_W-1:0] out_off_r;
  logic [KPS_OUT_W-1:0] out_len_r;
  logic                 out_last_r;

  logic                 in_fire;
  logic                 has_room;
  logic [CNT_W-1:0]     cnt_inc;
  logic [31:0]          pc_wide;
  logic [PART_W-1:0]    pc_clamp;
  logic [PART_W:0]      rem_sh;
  logic                 q_bit;
  logic [CNT_W:0]       pos_plus;
  logic                 re;
  logic [ADDR_W-1:0]    raddr;

  // no word taken while in reset
  assign in.ready = cmd.load_en && rst_n;
  assign in_fire  = in.valid && cmd.load_en && rst_n;
  assign has_room = cnt_r < CNT_W'(MAX_KEYS);
  assign cnt_inc  = has_room ? cnt_r + CNT_W'(1) : cnt_r;

  // part count clamped to one .. max parts
  always_comb begin
    pc_wide = 32'(pcnt_r);
    if (pc_wide == 32'd0) begin
      pc_clamp = PART_W'(1);
    end else if (pc_wide > 32'(MAX_PARTS)) begin
      pc_clamp = PART_W'(MAX_PARTS);
    end else begin
      pc_clamp = PART_W'(pc_wide);
    end
  end

  // one quotient bit per step
  assign rem_sh  = {rem_r, quo_r[CNT_W-1]};
  assign q_bit   = rem_sh >= {1'b0, parts_r};
  assign rem_nxt = q_bit ? PART_W'(rem_sh - {1'b0, parts_r}) : rem_sh[PART_W-1:0];
  assign quo_nxt = {quo_r[CNT_W-2:0], q_bit};

  assign pos_plus = pos_r + {1'b0, quo_r};

  assign re    = cmd.rd_pos || cmd.rd_b;
  assign raddr = cmd.rd_pos ? pos_r[ADDR_W-1:0] : b_r[ADDR_W-1:0];

  kps_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (MAX_KEYS)
  ) u_store (
    .clk   (clk),
    .we    (in_fire && has_room),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (in.key),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r      <= KPS_CFG_W'(1);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        pcnt_r <= cfg_wdata;
      end
      if (in_fire) begin
        cnt_r <= in.last_key ? '0 : cnt_inc;
      end
      if (cmd.push_mid || cmd.push_last) begin
        out_valid_r <= 1'b1;
      end else if (out.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in.last_key) begin
      len_r   <= cnt_inc;
      quo_r   <= cnt_inc;
      rem_r   <= '0;
      dcnt_r  <= '0;
      parts_r <= pc_clamp;
    end
    if (cmd.div_step) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      dcnt_r <= dcnt_r + DC_W'(1);
      if (st.div_last) begin
        pos_r  <= {1'b0, quo_nxt};
        prev_r <= '0;
        idx_r  <= PART_W'(1);
      end
    end
    if (cmd.ref_cap) begin
      ref_r <= rdata;
      b_r   <= pos_r[CNT_W-1:0] + CNT_W'(1);
    end
    if (cmd.b_inc) begin
      b_r <= b_r + CNT_W'(1);
    end
    if (cmd.b_len) begin
      b_r <= len_r;
    end
    if (cmd.push_mid) begin
      out_off_r  <= KPS_OUT_W'(prev_r);
      out_len_r  <= KPS_OUT_W'(b_r - prev_r);
      out_last_r <= 1'b0;
      if (({1'b0, b_r} < pos_plus) && (b_r < len_r)) begin
        pos_r <= pos_plus;
      end else begin
        pos_r <= {1'b0, b_r};
      end
      prev_r <= b_r;
      idx_r  <= idx_r + PART_W'(1);
    end
    if (cmd.push_last) begin
      out_off_r  <= KPS_OUT_W'(prev_r);
      out_len_r  <= KPS_OUT_W'(len_r - prev_r);
      out_last_r <= 1'b1;
    end
  end

  assign out.valid       = out_valid_r;
  assign out.part_offset = out_off_r;
  assign out.part_length = out_len_r;
  assign out.last_part   = out_last_r;

  always_comb begin
    st            = '0;
    st.in_fire    = in_fire;
    st.in_last    = in.last_key;
    st.div_last   = dcnt_r == DC_W'(CNT_W - 1);
    st.pos_ge_len = pos_r >= {1'b0, len_r};
    st.b_ge_len   = b_r >= len_r;
    st.key_eq     = rdata == ref_r;
    st.out_free   = !out_valid_r || out.ready;
    st.idx_end    = idx_r == parts_r;
  end

endmodule

`default_nettype wire

// File: rtl/key_run_partition_boundaries.sv
// key run partition top: keys load one per cycle in the load state, the marked key starts the
// split. then the divider divides the key count by the part count; per inner part a check, a
// reference read, a scan and a compare per key after the boundary, one more scan if the scan
// hits the batch end, one push. clamped and final parts take check and push only; each word
// waits in push until the output is free; no key taken until the final word is registered.
// synchronous active-low reset clears fill count, sequencer, output valid; part count 1
`default_nettype none

module key_run_partition_boundaries
  import kps_pkg::*;
#(
  parameter int MAX_KEYS  = KPS_MAX_KEYS,
  parameter int MAX_PARTS = KPS_MAX_PARTS,
  parameter int KEY_BITS  = KPS_KEY_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [KPS_CFG_W-1:0] cfg_wdata,
  kps_key_if.sink                   in,
  kps_part_if.source                out
);

  kps_cmd_t    cmd;
  kps_status_t st;

  kps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  kps_dp #(
    .MAX_KEYS  (MAX_KEYS),
    .MAX_PARTS (MAX_PARTS),
    .KEY_BITS  (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in        (in),
    .out       (out),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

`default_nettype wire
